FILE: hw/rtl/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// types, codes and sizes shared by the cell list neighbour search unit
// ----------------------------------------------------------------------------
package clns_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PT_W       = 10;             // point index
  localparam int CNT_W      = 11;             // point count, holds MAX_POINTS
  localparam int CELLS_AXIS = 16;
  localparam int CA_W       = 4;              // cell coordinate on one axis
  localparam int DIM_W      = 5;              // cells per axis, holds CELLS_AXIS
  localparam int CELL_W     = 3 * CA_W;       // flat cell index
  localparam int NCELLS     = CELLS_AXIS * CELLS_AXIS * CELLS_AXIS;
  localparam int MAX_NB     = 64;
  localparam int NB_W       = 6;              // neighbour buffer address
  localparam int COORD_W    = 32;
  localparam int CUT_W      = 31;

  localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(MAX_POINTS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_BUILD = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE      = 2'd0,
    KIND_NEIGHBOUR = 2'd1,
    KIND_NONE      = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  localparam logic REG_CUTOFF   = 1'b0;
  localparam logic REG_PERIODIC = 1'b1;

  // flat cell index: (cz * dy + cy) * dx + cx
  function automatic logic [CELL_W-1:0] cell_of(input logic [CA_W-1:0] cx,
                                                 input logic [CA_W-1:0] cy,
                                                 input logic [CA_W-1:0] cz,
                                                 input logic [DIM_W-1:0] dx,
                                                 input logic [DIM_W-1:0] dy);
    logic [CELL_W+1:0] t;
    t = (((CELL_W+2)'(cz) * (CELL_W+2)'(dy)) + (CELL_W+2)'(cy)) * (CELL_W+2)'(dx)
        + (CELL_W+2)'(cx);
    return t[CELL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/cell_list_neighbour_search_unit.sv
// ----------------------------------------------------------------------------
// cell_list_neighbour_search_unit
// cell linked list neighbour search over 3d points in signed q15.16
// ----------------------------------------------------------------------------
// usage: items enter on the s_axis channel, opcode in tuser. clear gives no
// result, and load gives none unless the set is full, when it gives an error
// item. build scans the points for the bounding box, sizes the grid with a
// shared adder, sweeps all 4096 cell heads and bins each point with a 5 step
// restoring divider, then gives one done item, or an error item if the set
// is empty. a query reads the query point, walks up to 27 cells and their
// chains, using the shared multiplier and the distance sequencer, buffers
// up to 64 hits and then sends them with tlast on the final one.
// s_axis_tready is high only while the sequencer is idle; one item is worked
// at a time. results sit in an output register that holds while m_axis_tready
// is low; the sequencer waits on it. reset (synchronous, rst) empties the set,
// drops the grid and restores the cutoff of 1.0; cell heads need no clearing
// pass since a query only runs after a build, and a build sweeps them.
// configuration is written through cfg_wr_en / cfg_index / cfg_data while idle.
module cell_list_neighbour_search_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], query_index[105:96], zero pad
  input  logic [111:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // neighbour_index[9:0], zero pad
  output logic [15:0]  m_axis_tdata,
  // result_kind[1:0], truncated[2]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);
  import clns_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_OUT_ONE,
    S_MM_RD, S_MM_CMP, S_EXT, S_DIMS, S_CLR,
    S_BIN_RD, S_BIN_MUL, S_BIN_DIV0, S_BIN_DIV, S_BIN_AX, S_BIN_CELL, S_BIN_LINK,
    S_Q_RD, S_Q_SQ, S_Q_LIST, S_CELL, S_HEAD, S_CHK, S_RD_J, S_J,
    S_D1, S_D2, S_D3, S_D4, S_TEST, S_DEC, S_EMIT_RD, S_EMIT_WR
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // memories
  coord_t             x_mem [MAX_POINTS];
  coord_t             y_mem [MAX_POINTS];
  coord_t             z_mem [MAX_POINTS];
  logic [CELL_W-1:0]  pc_mem [MAX_POINTS];   // packed cell coordinates cz,cy,cx
  logic [CNT_W-1:0]   cn_mem [MAX_POINTS];   // chain next
  logic [CNT_W-1:0]   ch_mem [NCELLS];       // cell head
  logic [PT_W-1:0]    nb_mem [MAX_NB];       // neighbour buffer

  coord_t             x_rd, y_rd, z_rd;
  logic [CELL_W-1:0]  pc_rd;
  logic [CNT_W-1:0]   cn_rd, ch_rd;
  logic [PT_W-1:0]    nb_rd;

  // control and data registers
  state_t              state;
  logic [CUT_W-1:0]    cutoff;
  logic                periodic;
  logic [CNT_W-1:0]    point_count;
  logic                built;
  coord_t              bmin [3];
  coord_t              lo [3];
  coord_t              hi [3];
  logic [COORD_W-1:0]  ext [3];
  logic [DIM_W-1:0]    dim [3];
  logic [PT_W-1:0]     idx;
  logic [1:0]          ax;
  logic [DIM_W-1:0]    kcnt;
  logic [35:0]         acc;
  logic [CELL_W-1:0]   sweep;
  logic [36:0]         rem;
  logic [DIM_W-1:0]    quo;
  logic [2:0]          step;
  logic [CA_W-1:0]     coord [3];
  logic [63:0]         prod;
  logic [PT_W-1:0]     qidx;
  coord_t              qpos [3];
  logic [CELL_W-1:0]   home;
  logic [61:0]         cutsq;
  logic [CA_W-1:0]     lst [3][3];
  logic [1:0]          cnt [3];
  logic [1:0]          ix, iy, iz;
  logic [CNT_W-1:0]    j, nxt;
  logic [COORD_W-1:0]  ad;
  logic                fail;
  logic [63:0]         sum;
  logic [CNT_W-1:0]    found;
  logic [NB_W:0]       nout;
  logic [NB_W-1:0]     k;
  logic                trunc;
  kind_t               res_kind;
  logic                out_valid;
  kind_t               out_kind;
  logic [PT_W-1:0]     out_idx;
  logic                out_last, out_trunc;

  // input fields
  op_t                 in_op;
  coord_t              in_x, in_y, in_z;
  logic [PT_W-1:0]     in_q;
  logic                accept;

  assign in_op  = op_t'(s_axis_tuser[1:0]);
  assign in_x   = s_axis_tdata[31:0];
  assign in_y   = s_axis_tdata[63:32];
  assign in_z   = s_axis_tdata[95:64];
  assign in_q   = s_axis_tdata[105:96];
  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_idx};
  assign m_axis_tuser  = {out_trunc, out_kind};
  assign m_axis_tlast  = out_last;

  // helpers
  logic [CUT_W-1:0]    cut_eff;
  logic                full;
  logic                out_free;
  logic                out_load;
  logic [CELL_W-1:0]   bin_cell, q_cell;
  coord_t              pj;
  logic [COORD_W-1:0]  dpos;
  logic [36:0]         div_sh;
  logic [32:0]         dj;
  logic [COORD_W-1:0]  alt;
  logic                last_pt;
  logic                cell_done;
  logic                pass;
  logic [CA_W-1:0]     lst_c [3][3];
  logic [1:0]          cnt_c [3];

  assign cut_eff  = (cutoff == '0) ? CUT_W'(1) : cutoff;
  assign full     = (point_count >= EMPTY_MARK);
  assign out_free = !out_valid || m_axis_tready;
  // output register takes a new item this cycle
  assign out_load = ((state == S_OUT_ONE) || (state == S_EMIT_WR)) && out_free;
  assign bin_cell = cell_of(coord[0], coord[1], coord[2], dim[0], dim[1]);
  assign q_cell   = cell_of(lst[0][ix], lst[1][iy], lst[2][iz], dim[0], dim[1]);
  assign last_pt  = ({1'b0, idx} + CNT_W'(1)) == point_count;
  assign cell_done = (32'(ix) + 1 >= 32'(cnt[0])) && (32'(iy) + 1 >= 32'(cnt[1]))
                  && (32'(iz) + 1 >= 32'(cnt[2]));
  assign pass     = !fail && (sum <= {2'b0, cutsq});

  always_comb begin
    case (ax)
      2'd0:    pj = x_rd;
      2'd1:    pj = y_rd;
      default: pj = z_rd;
    endcase
  end
  assign dpos   = COORD_W'(pj - bmin[ax]);
  assign div_sh = {5'b0, ext[ax]} << step;
  assign dj     = {pj[COORD_W-1], pj} - {qpos[ax][COORD_W-1], qpos[ax]};
  assign alt    = ext[ax] - ad;

  // neighbour cell list of each axis, wrapped cells visited once
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [DIM_W-1:0] h5, c0, c2;
      logic v0, v2, dup1, dup2;
      logic [1:0] n;
      h5 = {1'b0, home[a*CA_W +: CA_W]};
      c0 = (h5 == '0) ? dim[a] - DIM_W'(1) : h5 - DIM_W'(1);
      c2 = (h5 + DIM_W'(1) >= dim[a]) ? '0 : h5 + DIM_W'(1);
      v0 = periodic || (h5 != '0);
      v2 = periodic || (h5 + DIM_W'(1) < dim[a]);
      dup1 = v0 && (c0 == h5);
      dup2 = (v0 && (c2 == c0)) || (c2 == h5);
      lst_c[a][0] = '0;
      lst_c[a][1] = '0;
      lst_c[a][2] = '0;
      n = 2'd0;
      if (v0) begin
        lst_c[a][0] = c0[CA_W-1:0];
        n = 2'd1;
      end
      if (!dup1) begin
        lst_c[a][n] = h5[CA_W-1:0];
        n = n + 2'd1;
      end
      if (v2 && !dup2) begin
        lst_c[a][n] = c2[CA_W-1:0];
        n = n + 2'd1;
      end
      cnt_c[a] = n;
    end
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (state)
      S_BIN_MUL: begin
        mul_a = dpos;
        mul_b = 32'(dim[ax]);
      end
      S_Q_SQ: begin
        mul_a = 32'(cutoff);
        mul_b = 32'(cutoff);
      end
      S_D3: begin
        mul_a = ad;
        mul_b = ad;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // memory controls
  logic              pos_we, mem_re, ch_re, ch_we, link_we, nb_we, nb_re;
  logic [PT_W-1:0]   mem_raddr;
  logic [CELL_W-1:0] ch_raddr, ch_waddr;
  logic [CNT_W-1:0]  ch_wdata;

  assign pos_we  = accept && (in_op == OP_LOAD) && !full;
  assign mem_re  = (state == S_MM_RD) || (state == S_BIN_RD) || (state == S_Q_RD)
                || (state == S_RD_J);
  assign ch_re   = (state == S_BIN_CELL) || (state == S_CELL);
  assign ch_we   = (state == S_CLR) || (state == S_BIN_LINK);
  assign link_we = (state == S_BIN_LINK);
  assign nb_we   = (state == S_TEST) && pass && (found < CNT_W'(MAX_NB));
  assign nb_re   = (state == S_EMIT_RD);

  always_comb begin
    case (state)
      S_Q_RD:  mem_raddr = qidx;
      S_RD_J:  mem_raddr = j[PT_W-1:0];
      default: mem_raddr = idx;
    endcase
  end
  assign ch_raddr = (state == S_CELL) ? q_cell : bin_cell;
  assign ch_waddr = (state == S_CLR) ? sweep : bin_cell;
  assign ch_wdata = (state == S_CLR) ? EMPTY_MARK : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (pos_we) begin
      x_mem[point_count[PT_W-1:0]] <= in_x;
      y_mem[point_count[PT_W-1:0]] <= in_y;
      z_mem[point_count[PT_W-1:0]] <= in_z;
    end
    if (mem_re) begin
      x_rd  <= x_mem[mem_raddr];
      y_rd  <= y_mem[mem_raddr];
      z_rd  <= z_mem[mem_raddr];
      pc_rd <= pc_mem[mem_raddr];
      cn_rd <= cn_mem[mem_raddr];
    end
    if (link_we) begin
      pc_mem[idx] <= {coord[2], coord[1], coord[0]};
      cn_mem[idx] <= ch_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_waddr] <= ch_wdata;
    if (ch_re) ch_rd <= ch_mem[ch_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[found[NB_W-1:0]] <= j[PT_W-1:0];
    if (nb_re) nb_rd <= nb_mem[k];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cutoff      <= CUT_W'(65536);
      periodic    <= 1'b0;
      point_count <= '0;
      built       <= 1'b0;
      out_valid   <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        bmin[a] <= '0;
        ext[a]  <= '0;
        dim[a]  <= DIM_W'(1);
      end
    end else begin
      prod <= 64'(mul_a) * 64'(mul_b);
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_CLEAR: begin
                point_count <= '0;
                built       <= 1'b0;
              end
              OP_LOAD: begin
                if (full) begin
                  res_kind <= KIND_ERROR;
                  state    <= S_OUT_ONE;
                end else begin
                  point_count <= point_count + CNT_W'(1);
                  built       <= 1'b0;
                end
              end
              OP_BUILD: begin
                if (point_count == '0) begin
                  built    <= 1'b0;
                  res_kind <= KIND_ERROR;
                  state    <= S_OUT_ONE;
                end else begin
                  idx   <= '0;
                  state <= S_MM_RD;
                end
              end
              default: begin
                qidx <= in_q;
                if (!built || ({1'b0, in_q} >= point_count)) begin
                  res_kind <= KIND_ERROR;
                  state    <= S_OUT_ONE;
                end else begin
                  state <= S_Q_RD;
                end
              end
            endcase
          end
        end

        S_OUT_ONE: begin
          if (out_free) begin
            out_kind  <= res_kind;
            out_idx   <= '0;
            out_last  <= 1'b1;
            out_trunc <= 1'b0;
            state     <= S_IDLE;
          end
        end

        // bounding box
        S_MM_RD: state <= S_MM_CMP;
        S_MM_CMP: begin
          for (int a = 0; a < 3; a++) begin
            coord_t v;
            v = (a == 0) ? x_rd : ((a == 1) ? y_rd : z_rd);
            if (idx == '0 || v < lo[a]) lo[a] <= v;
            if (idx == '0 || v > hi[a]) hi[a] <= v;
          end
          if (last_pt) begin
            state <= S_EXT;
          end else begin
            idx   <= idx + PT_W'(1);
            state <= S_MM_RD;
          end
        end
        S_EXT: begin
          for (int a = 0; a < 3; a++) begin
            bmin[a] <= lo[a];
            ext[a]  <= COORD_W'(hi[a] - lo[a]);
          end
          ax    <= 2'd0;
          kcnt  <= DIM_W'(1);
          acc   <= 36'(cut_eff);
          state <= S_DIMS;
        end
        // cells per axis: largest k up to 16 with k * cut <= extent, and at least 1
        S_DIMS: begin
          if ((kcnt < DIM_W'(CELLS_AXIS)) && (acc + 36'(cut_eff) <= 36'(ext[ax]))) begin
            acc  <= acc + 36'(cut_eff);
            kcnt <= kcnt + DIM_W'(1);
          end else begin
            dim[ax] <= kcnt;
            if (ax == 2'd2) begin
              sweep <= '0;
              state <= S_CLR;
            end else begin
              ax   <= ax + 2'd1;
              kcnt <= DIM_W'(1);
              acc  <= 36'(cut_eff);
            end
          end
        end
        S_CLR: begin
          sweep <= sweep + CELL_W'(1);
          if (sweep == CELL_W'(NCELLS - 1)) begin
            idx   <= '0;
            state <= S_BIN_RD;
          end
        end

        // binning
        S_BIN_RD: begin
          ax    <= 2'd0;
          state <= S_BIN_MUL;
        end
        S_BIN_MUL: state <= S_BIN_DIV0;
        S_BIN_DIV0: begin
          rem   <= prod[36:0];
          quo   <= '0;
          step  <= 3'd4;
          state <= S_BIN_DIV;
        end
        S_BIN_DIV: begin
          if (rem >= div_sh) begin
            rem       <= rem - div_sh;
            quo[step] <= 1'b1;
          end
          if (step == 3'd0) state <= S_BIN_AX;
          else step <= step - 3'd1;
        end
        S_BIN_AX: begin
          if (ext[ax] == '0) coord[ax] <= '0;
          else if (quo >= dim[ax]) coord[ax] <= CA_W'(dim[ax] - DIM_W'(1));
          else coord[ax] <= quo[CA_W-1:0];
          if (ax == 2'd2) begin
            state <= S_BIN_CELL;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_BIN_MUL;
          end
        end
        S_BIN_CELL: state <= S_BIN_LINK;
        S_BIN_LINK: begin
          if (last_pt) begin
            built    <= 1'b1;
            res_kind <= KIND_DONE;
            state    <= S_OUT_ONE;
          end else begin
            idx   <= idx + PT_W'(1);
            state <= S_BIN_RD;
          end
        end

        // query setup
        S_Q_RD: state <= S_Q_SQ;
        S_Q_SQ: begin
          qpos[0] <= x_rd;
          qpos[1] <= y_rd;
          qpos[2] <= z_rd;
          home    <= pc_rd;
          state   <= S_Q_LIST;
        end
        S_Q_LIST: begin
          cutsq <= prod[61:0];
          lst   <= lst_c;
          cnt   <= cnt_c;
          ix    <= '0;
          iy    <= '0;
          iz    <= '0;
          found <= '0;
          state <= S_CELL;
        end

        // cell and chain walk
        S_CELL: state <= S_HEAD;
        S_HEAD: begin
          j     <= ch_rd;
          state <= S_CHK;
        end
        S_CHK: begin
          if (j >= point_count) begin
            if (cell_done) begin
              state <= S_DEC;
            end else begin
              state <= S_CELL;
              if (32'(ix) + 1 < 32'(cnt[0])) begin
                ix <= ix + 2'd1;
              end else begin
                ix <= '0;
                if (32'(iy) + 1 < 32'(cnt[1])) begin
                  iy <= iy + 2'd1;
                end else begin
                  iy <= '0;
                  iz <= iz + 2'd1;
                end
              end
            end
          end else begin
            state <= S_RD_J;
          end
        end
        S_RD_J: state <= S_J;
        S_J: begin
          nxt <= cn_rd;
          if (j == {1'b0, qidx}) begin
            j     <= cn_rd;
            state <= S_CHK;
          end else begin
            ax    <= 2'd0;
            sum   <= '0;
            fail  <= 1'b0;
            state <= S_D1;
          end
        end

        // distance, one axis per pass
        S_D1: begin
          ad    <= dj[32] ? COORD_W'(-dj) : dj[COORD_W-1:0];
          state <= S_D2;
        end
        S_D2: begin
          if (periodic && (ax != 2'd2) && (ad <= ext[ax]) && (alt < ad)) ad <= alt;
          state <= S_D3;
        end
        S_D3: begin
          if (ad > 32'(cutoff)) fail <= 1'b1;
          state <= S_D4;
        end
        S_D4: begin
          sum <= sum + prod;
          if (ax == 2'd2) begin
            state <= S_TEST;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_D1;
          end
        end
        S_TEST: begin
          if (pass) found <= found + CNT_W'(1);
          j     <= nxt;
          state <= S_CHK;
        end

        // results
        S_DEC: begin
          if (found == '0) begin
            res_kind <= KIND_NONE;
            state    <= S_OUT_ONE;
          end else begin
            nout  <= (found > CNT_W'(MAX_NB)) ? (NB_W+1)'(MAX_NB) : found[NB_W:0];
            trunc <= (found > CNT_W'(MAX_NB));
            k     <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_WR;
        S_EMIT_WR: begin
          if (out_free) begin
            out_kind  <= KIND_NEIGHBOUR;
            out_idx   <= nb_rd;
            out_last  <= ({1'b0, k} + (NB_W+1)'(1)) == nout;
            out_trunc <= trunc;
            if (({1'b0, k} + (NB_W+1)'(1)) == nout) begin
              state <= S_IDLE;
            end else begin
              k     <= k + NB_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end

        default: state <= S_IDLE;
      endcase

      // configuration writes, meant to come only while idle; the block itself does not enforce it
      if (cfg_wr_en) begin
        if (cfg_index == REG_CUTOFF) begin
          cutoff <= cfg_data;
          built  <= 1'b0;
        end else if (cfg_index == REG_PERIODIC) begin
          periodic <= cfg_data[0];
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cell list neighbour search unit: point sets
// are loaded, the grid is built and neighbours are queried, with the
// expected items worked out by a local model of the grid and the search
// ----------------------------------------------------------------------------
module tb;
  import clns_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], query_index[105:96], zero pad
  logic [111:0] s_axis_tdata = '0;
  // opcode[1:0]
  logic [1:0]   s_axis_tuser = OP_CLEAR;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // neighbour_index[9:0], zero pad
  logic [15:0]  m_axis_tdata;
  // result_kind[1:0], truncated[2]
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_index = REG_CUTOFF;
  logic [30:0]  cfg_data = '0;

  cell_list_neighbour_search_unit dut (.*);

  typedef struct {
    op_t        op;
    logic [31:0] x, y, z;
    logic [9:0] qi;
  } cmd_t;

  typedef struct {
    kind_t      kind;
    logic [9:0] idx;
    bit         last;
    bit         trunc;
  } hit_t;

  cmd_t  pend_cmds[$];
  hit_t  hits_due[$];
  int    n_fail = 0;
  int    n_sent = 0;
  bit    calm = 1'b0;       // no idling on either side
  int    s_gap = 0, r_gap = 0;
  cmd_t  cur;

  // local copy of the block state
  longint          pos_s[3][MAX_POINTS];
  int              pcell[MAX_POINTS];
  int              nxt[MAX_POINTS];
  int              head[NCELLS];
  int              npts = 0;
  longint          bmin[3];
  longint unsigned ext[3];
  int              dims[3] = '{1, 1, 1};
  bit              built = 1'b0;
  longint unsigned cutoff = 65536;
  bit              periodic = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic void add_hit(kind_t k, int idx, bit last, bit trunc);
    hit_t h;
    h.kind = k; h.idx = idx[9:0]; h.last = last; h.trunc = trunc;
    hits_due = {hits_due, h};
  endfunction

  function automatic void build_grid();
    longint lo, hi;
    longint unsigned cut, q, d, ci;
    int c[3];
    int cv;
    cut = (cutoff == 0) ? 1 : cutoff;
    if (npts == 0) begin
      built = 1'b0;
      add_hit(KIND_ERROR, 0, 1'b1, 1'b0);
      return;
    end
    for (int a = 0; a < 3; a++) begin
      lo = pos_s[a][0];
      hi = pos_s[a][0];
      for (int i = 1; i < npts; i++) begin
        if (pos_s[a][i] < lo) lo = pos_s[a][i];
        if (pos_s[a][i] > hi) hi = pos_s[a][i];
      end
      bmin[a] = lo;
      ext[a] = hi - lo;
      q = ext[a] / cut;
      if (q < 1) q = 1;
      if (q > CELLS_AXIS) q = CELLS_AXIS;
      dims[a] = int'(q);
    end
    for (int i = 0; i < NCELLS; i++) head[i] = MAX_POINTS;
    for (int i = 0; i < npts; i++) begin
      for (int a = 0; a < 3; a++) begin
        d = pos_s[a][i] - bmin[a];
        ci = (ext[a] != 0) ? (d * dims[a]) / ext[a] : 0;
        if (ci >= dims[a]) ci = dims[a] - 1;
        c[a] = int'(ci);
      end
      cv = (c[2] * dims[1] + c[1]) * dims[0] + c[0];
      nxt[i] = head[cv];
      head[cv] = i;
      pcell[i] = cv;
    end
    built = 1'b1;
    add_hit(KIND_DONE, 0, 1'b1, 1'b0);
  endfunction

  // squared distance test, minimum image in x and y when periodic
  function automatic bit in_reach(int p, int q);
    longint d;
    longint unsigned ad, alt, sum;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      d = pos_s[a][p] - pos_s[a][q];
      ad = (d < 0) ? -d : d;
      if (periodic && a < 2 && ad <= ext[a]) begin
        alt = ext[a] - ad;
        if (alt < ad) ad = alt;
      end
      if (ad > cutoff) return 1'b0;
      sum += ad * ad;
    end
    return sum <= cutoff * cutoff;
  endfunction

  function automatic void search(int q);
    int home[3], lst[3][3], cnt[3];
    int v, found, j, steps, c, n;
    bit dup;
    int nb[$];
    if (!built || q >= npts) begin
      add_hit(KIND_ERROR, 0, 1'b1, 1'b0);
      return;
    end
    home[0] = pcell[q] % dims[0];
    home[1] = (pcell[q] / dims[0]) % dims[1];
    home[2] = pcell[q] / dims[0] / dims[1];
    for (int a = 0; a < 3; a++) begin
      cnt[a] = 0;
      for (int o = -1; o <= 1; o++) begin
        v = home[a] + o;
        dup = 1'b0;
        if (periodic) begin
          if (v < 0) v = dims[a] - 1;
          if (v >= dims[a]) v = 0;
        end else if (v < 0 || v >= dims[a]) begin
          continue;
        end
        for (int k = 0; k < cnt[a]; k++) if (lst[a][k] == v) dup = 1'b1;
        if (!dup) begin
          lst[a][cnt[a]] = v;
          cnt[a]++;
        end
      end
    end
    found = 0;
    // scan z, then y, then x; each chain from the highest index down
    for (int iz = 0; iz < cnt[2]; iz++)
      for (int iy = 0; iy < cnt[1]; iy++)
        for (int ix = 0; ix < cnt[0]; ix++) begin
          c = (lst[2][iz] * dims[1] + lst[1][iy]) * dims[0] + lst[0][ix];
          j = head[c];
          steps = 0;
          while (j < npts && steps < npts) begin
            if (j != q && in_reach(q, j)) begin
              if (found < MAX_NB) nb = {nb, j};
              found++;
            end
            j = nxt[j];
            steps++;
          end
        end
    if (found == 0) begin
      add_hit(KIND_NONE, 0, 1'b1, 1'b0);
      return;
    end
    n = nb.size();
    for (int k = 0; k < n; k++) add_hit(KIND_NEIGHBOUR, nb[k], k == n - 1, found > MAX_NB);
  endfunction

  function automatic void predict(cmd_t it);
    case (it.op)
      OP_CLEAR: begin
        npts = 0;
        built = 1'b0;
      end
      OP_LOAD: begin
        if (npts >= MAX_POINTS) begin
          add_hit(KIND_ERROR, 0, 1'b1, 1'b0);
        end else begin
          pos_s[0][npts] = longint'(signed'(it.x));
          pos_s[1][npts] = longint'(signed'(it.y));
          pos_s[2][npts] = longint'(signed'(it.z));
          npts++;
          built = 1'b0;
        end
      end
      OP_BUILD: build_grid();
      default: search(int'(it.qi));
    endcase
  endfunction

  // sender: one item at a time from the pending queue, random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict(cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_gap > 0) begin
          s_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          s_gap = $urandom_range(1, 18) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pend_cmds.size() > 0) begin
          cur = pend_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur.op;
          s_axis_tdata  <= {6'b0, cur.qi, cur.z, cur.y, cur.x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each item against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_due.size() == 0) begin
          $display("%0t: unexpected item kind %0d index %0d last %0b trunc %0b", $time,
                   m_axis_tuser[1:0], m_axis_tdata[9:0], m_axis_tlast, m_axis_tuser[2]);
          n_fail++;
        end else begin
          hit_t h;
          h = hits_due.pop_front();
          if (m_axis_tuser[1:0] !== h.kind || m_axis_tdata[9:0] !== h.idx ||
              m_axis_tlast !== h.last || m_axis_tuser[2] !== h.trunc) begin
            $display("%0t: expected kind %0d index %0d last %0b trunc %0b", $time,
                     h.kind, h.idx, h.last, h.trunc);
            $display("%0t:   actual kind %0d index %0d last %0b trunc %0b", $time,
                     m_axis_tuser[1:0], m_axis_tdata[9:0], m_axis_tlast, m_axis_tuser[2]);
            n_fail++;
          end
        end
      end
      if (r_gap > 0) begin
        r_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        r_gap = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_cmd(op_t op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [9:0] qi);
    cmd_t it;
    it.op = op; it.x = x; it.y = y; it.z = z; it.qi = qi;
    pend_cmds = {pend_cmds, it};
    n_sent++;
  endtask

  // waits until every item is sent and everything due has come back
  task automatic drain();
    do @(posedge clk);
    while (pend_cmds.size() > 0 || s_axis_tvalid || hits_due.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_CUTOFF) begin
      cutoff = val;
      built = 1'b0;
    end else begin
      periodic = val[0];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // clear, load a set, build, then query it; now and then a query ahead of the build or a late load
  task automatic run_set(int n, bit wild, int nq);
    longint base[3], span, p;
    logic [31:0] c[3];
    span = (cutoff > (64'd1 << 28)) ? (64'd1 << 31) : cutoff * 5 + 1;
    for (int a = 0; a < 3; a++) base[a] = longint'(signed'($urandom()));
    push_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom(), 10'($urandom()));
    for (int i = 0; i < n; i++) begin
      for (int a = 0; a < 3; a++) begin
        p = base[a] + longint'($urandom_range(0, 32'(span - 1)));
        c[a] = wild ? $urandom() : p[31:0];
      end
      push_cmd(OP_LOAD, c[0], c[1], c[2], 10'($urandom()));
    end
    // occasional query ahead of the build
    if ($urandom_range(0, 5) == 0) push_cmd(OP_QUERY, '0, '0, '0, 10'd0);
    push_cmd(OP_BUILD, $urandom(), $urandom(), $urandom(), 10'($urandom()));
    for (int k = 0; k < nq; k++)
      push_cmd(OP_QUERY, $urandom(), $urandom(), $urandom(),
               ($urandom_range(0, 7) == 0) ? 10'($urandom()) : 10'($urandom_range(0, n - 1)));
    if ($urandom_range(0, 6) == 0) begin
      push_cmd(OP_LOAD, $urandom(), $urandom(), $urandom(), '0);
      push_cmd(OP_QUERY, '0, '0, '0, 10'd0);
    end
  endtask

  initial begin
    logic [30:0] cut_pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, extremes of the coordinates, coincident points,
    // a point exactly at the cutoff, index out of range
    push_cmd(OP_QUERY, '0, '0, '0, 10'd0);
    push_cmd(OP_BUILD, '0, '0, '0, '0);
    push_cmd(OP_LOAD, 32'd0, 32'd0, 32'd0, '0);
    push_cmd(OP_LOAD, 32'd0, 32'd0, 32'd0, '0);
    push_cmd(OP_LOAD, 32'd65536, 32'd0, 32'd0, '0);
    push_cmd(OP_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    push_cmd(OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'h3ff);
    push_cmd(OP_BUILD, '0, '0, '0, '0);
    for (int i = 0; i < 5; i++) push_cmd(OP_QUERY, '0, '0, '0, 10'(i));
    push_cmd(OP_QUERY, '0, '0, '0, 10'd5);
    push_cmd(OP_QUERY, '0, '0, '0, 10'h3ff);
    drain();
    // periodic wrap over the same set
    write_reg(REG_PERIODIC, 31'd1);
    write_reg(REG_CUTOFF, 31'h7fff_ffff);
    push_cmd(OP_QUERY, '0, '0, '0, 10'd0);
    push_cmd(OP_BUILD, '0, '0, '0, '0);
    for (int i = 0; i < 5; i++) push_cmd(OP_QUERY, '0, '0, '0, 10'(i));
    drain();

    // a set of 80 points at a cutoff of 1.0, not periodic
    write_reg(REG_PERIODIC, 31'd0);
    write_reg(REG_CUTOFF, 31'd65536);
    run_set(80, 1'b0, 3);
    drain();

    // random phases over several settings
    while (n_sent < 300) begin
      case ($urandom_range(0, 5))
        0: cut_pick = 31'd1;
        1: cut_pick = 31'h7fff_ffff;
        2: cut_pick = 31'($urandom());
        3: cut_pick = 31'd65536;
        default: cut_pick = 31'($urandom_range(1, 1 << 20));
      endcase
      write_reg(REG_CUTOFF, cut_pick);
      write_reg(REG_PERIODIC, 31'($urandom_range(0, 1)));
      if (n_sent > 240) calm = 1'b1;
      for (int s = $urandom_range(1, 3); s > 0; s--)
        run_set(($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24),
                $urandom_range(0, 4) == 0, $urandom_range(3, 8));
      drain();
    end

    calm = 1'b1;
    drain();
    repeat (100) @(posedge clk);
    if (n_fail == 0 && hits_due.size() == 0) begin
      $display("[cell_list_neighbour_search_unit] OK");
    end else begin
      $display("[cell_list_neighbour_search_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[cell_list_neighbour_search_unit] ERROR");
    $finish;
  end

endmodule
